// ===== rtl/quaternion_to_euler_angles_top_macros.svh =====
// assertion macros shared by the quaternion to euler angles rtl
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define Q2E_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("q2e same-cycle check failed");

// next-cycle implication, checked out of reset
`define Q2E_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("q2e next-cycle check failed");

`endif

// ===== rtl/q2e_pkg.sv =====
// shared constants, types and step functions of the quaternion to euler angles block
package q2e_pkg;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int RND_SHIFT       = 16 - ANGLE_FRAC_BITS;
  localparam int ANGLE_W         = 17;
  localparam int SQRT_STEPS      = 31;
  localparam int NORM_STEPS      = 6;
  localparam int CORDIC_STEPS    = 18;
  localparam int ATAN_LAT        = NORM_STEPS + CORDIC_STEPS + 2;
  localparam int XW              = 34;
  localparam int ZW              = 25;

  localparam logic [63:0] ONE60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] ONE59 = 64'h0800_0000_0000_0000;

  localparam logic signed [ZW-1:0] DEG90  = 25'sd5898240;
  localparam logic signed [ZW-1:0] DEG180 = 25'sd11796480;

  // operands of one arctangent: magnitudes plus quadrant signs
  typedef struct packed {
    logic [63:0] ax;
    logic [63:0] ay;
    logic        den_neg;
    logic        num_neg;
  } atan_in_t;

  // digit-by-digit square root state
  typedef struct packed {
    logic [34:0] rem;
    logic [30:0] root;
  } sq_t;

  function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] pair);
    logic [34:0] sh;
    logic [34:0] trial;
    sq_t         r;
    sh    = {s.rem[32:0], pair};
    trial = {2'b00, s.root, 2'b01};
    if (sh >= trial) begin
      r.rem  = sh - trial;
      r.root = {s.root[29:0], 1'b1};
    end else begin
      r.rem  = sh;
      r.root = {s.root[29:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [63:0] mag65(input logic signed [64:0] v);
    logic [64:0] n;
    n = v[64] ? 65'(-v) : 65'(v);
    return n[63:0];
  endfunction

  // atan(2^-i) in q16 degrees
  function automatic logic [22:0] atan_entry(input logic [4:0] i);
    logic [22:0] e;
    case (i)
      5'd0:    e = 23'd2949120;
      5'd1:    e = 23'd1740967;
      5'd2:    e = 23'd919879;
      5'd3:    e = 23'd466945;
      5'd4:    e = 23'd234379;
      5'd5:    e = 23'd117304;
      5'd6:    e = 23'd58666;
      5'd7:    e = 23'd29335;
      5'd8:    e = 23'd14668;
      5'd9:    e = 23'd7334;
      5'd10:   e = 23'd3667;
      5'd11:   e = 23'd1833;
      5'd12:   e = 23'd917;
      5'd13:   e = 23'd458;
      5'd14:   e = 23'd229;
      5'd15:   e = 23'd115;
      5'd16:   e = 23'd57;
      5'd17:   e = 23'd29;
      default: e = 23'd0;
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/quaternion_to_euler_angles_top.sv =====
// quaternion vector part to roll, pitch and yaw, fully pipelined
//
//  channel | ports                             | payload
//  --------+-----------------------------------+-------------------------------------
//  in      | in_tvalid in_tready in_tdata[95:0] | quat_x, quat_y, quat_z (q30 each)
//  out     | out_tvalid out_tready             | out_tdata[55:0] roll, pitch, yaw
//          | out_tdata out_tuser               | out_tuser norm_clamped
//
// one transaction enters per cycle while the pipeline advances; its length is
// set by two 31-stage square roots (scalar part, then the asin
// cosine) and the 26-stage arctangent units (normalize, 18 cordic steps, round)
// rst_n is synchronous, active low, and clears only the valid bits
// the whole pipeline advances together: it stalls only while a result sits
// in the output register and out_tready is low, so nothing is lost or repeated
`include "quaternion_to_euler_angles_top_macros.svh"

module quaternion_to_euler_angles_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // quat_x [31:0], quat_y [63:32], quat_z [95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // roll_angle [16:0], pitch_angle [32:17], yaw_angle [49:33]
  output logic        out_tuser   // norm_clamped [0]
);

  localparam int SQ    = q2e_pkg::SQRT_STEPS;
  localparam int A_END = 1 + SQ;            // valid index at the scalar root
  localparam int M_IDX = A_END + 1;         // w times x, y, z
  localparam int T_IDX = M_IDX + 1;         // atan2 / asin arguments
  localparam int P1_IDX = T_IDX + 1;        // asin argument magnitude
  localparam int B_END = P1_IDX + 2 + SQ;   // valid index at the cosine root
  localparam int LAT   = B_END + q2e_pkg::ATAN_LAT + 1;
  localparam logic [30:0] U_MAX = 31'h4000_0000;

  // side data carried alongside the scalar root
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [63:0] xy;
    logic signed [63:0] yz;
    logic signed [63:0] zx;
    logic signed [64:0] t1;
    logic signed [64:0] t4;
    logic               flag;
  } sa_t;

  typedef struct packed {
    q2e_pkg::sq_t sq;
    logic [61:0]  src;
    sa_t          side;
  } cha_t;

  // side data carried alongside the asin cosine root
  typedef struct packed {
    logic [30:0]        u;
    logic               t2neg;
    logic signed [64:0] t0;
    logic signed [64:0] t1;
    logic signed [64:0] t3;
    logic signed [64:0] t4;
    logic               flag;
  } sb_t;

  typedef struct packed {
    q2e_pkg::sq_t sq;
    logic [61:0]  src;
    sb_t          side;
  } chb_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [63:0]        xx;
    logic [63:0]        yy;
    logic [63:0]        zz;
    logic signed [63:0] xy;
    logic signed [63:0] yz;
    logic signed [63:0] zx;
  } s1_t;

  typedef struct packed {
    logic signed [63:0] wx;
    logic signed [63:0] wy;
    logic signed [63:0] wz;
    logic signed [63:0] xy;
    logic signed [63:0] yz;
    logic signed [63:0] zx;
    logic signed [64:0] t1;
    logic signed [64:0] t4;
    logic               flag;
  } m_t;

  typedef struct packed {
    logic signed [64:0] t0;
    logic signed [64:0] t1;
    logic signed [64:0] t2;
    logic signed [64:0] t3;
    logic signed [64:0] t4;
    logic               flag;
  } t_t;

  typedef struct packed {
    logic [61:0] uu;
    sb_t         side;
  } p2_t;

  logic adv;
  logic [LAT-1:0] vld_r;

  s1_t  s1_r;
  s1_t  s1_nxt;
  cha_t sqa_r [0:SQ];
  cha_t sa0_nxt;
  m_t   m_r;
  m_t   m_nxt;
  t_t   t_r;
  t_t   t_nxt;
  sb_t  p1_r;
  sb_t  p1_nxt;
  p2_t  p2_r;
  p2_t  p2_nxt;
  chb_t sqb_r [0:SQ];
  chb_t sb0_nxt;

  q2e_pkg::atan_in_t roll_op;
  q2e_pkg::atan_in_t pitch_op;
  q2e_pkg::atan_in_t yaw_op;
  logic [q2e_pkg::ANGLE_W-1:0] roll_ang;
  logic [q2e_pkg::ANGLE_W-1:0] pitch_ang;
  logic [q2e_pkg::ANGLE_W-1:0] yaw_ang;
  logic [q2e_pkg::ATAN_LAT-1:0] flag_dly_r;

  logic        out_tvalid_r;
  logic [55:0] out_tdata_r;
  logic        out_tuser_r;

  // global advance: the output register is free or being drained
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  // squares and cross products straight from the input transaction
  always_comb begin
    s1_nxt.x  = $signed(in_tdata[31:0]);
    s1_nxt.y  = $signed(in_tdata[63:32]);
    s1_nxt.z  = $signed(in_tdata[95:64]);
    s1_nxt.xx = 64'(s1_nxt.x * s1_nxt.x);
    s1_nxt.yy = 64'(s1_nxt.y * s1_nxt.y);
    s1_nxt.zz = 64'(s1_nxt.z * s1_nxt.z);
    s1_nxt.xy = s1_nxt.x * s1_nxt.y;
    s1_nxt.yz = s1_nxt.y * s1_nxt.z;
    s1_nxt.zx = s1_nxt.z * s1_nxt.x;
  end

  // sum of squares, norm check, radicand and the two cosine-side terms
  always_comb begin
    logic [63:0] sum;
    logic [63:0] sxy;
    logic [63:0] syz;
    logic [63:0] diff;
    sum  = s1_r.xx + s1_r.yy + s1_r.zz;
    sxy  = s1_r.xx + s1_r.yy;
    syz  = s1_r.yy + s1_r.zz;
    diff = q2e_pkg::ONE60 - sum;
    sa0_nxt.side.x    = s1_r.x;
    sa0_nxt.side.y    = s1_r.y;
    sa0_nxt.side.z    = s1_r.z;
    sa0_nxt.side.xy   = s1_r.xy;
    sa0_nxt.side.yz   = s1_r.yz;
    sa0_nxt.side.zx   = s1_r.zx;
    sa0_nxt.side.t1   = $signed({1'b0, q2e_pkg::ONE59}) - $signed({1'b0, sxy});
    sa0_nxt.side.t4   = $signed({1'b0, q2e_pkg::ONE59}) - $signed({1'b0, syz});
    sa0_nxt.side.flag = sum > q2e_pkg::ONE60;
    sa0_nxt.sq        = '0;
    sa0_nxt.src       = sa0_nxt.side.flag ? 62'd0 : {1'b0, diff[60:0]};
  end

  // scalar part: one root bit per stage
  for (genvar k = 1; k <= SQ; k++) begin : g_sqrt_w
    always_ff @(posedge clk) begin
      if (adv) begin
        sqa_r[k].sq   <= q2e_pkg::sqrt_step(sqa_r[k-1].sq, sqa_r[k-1].src[61:60]);
        sqa_r[k].src  <= {sqa_r[k-1].src[59:0], 2'b00};
        sqa_r[k].side <= sqa_r[k-1].side;
      end
    end
  end

  // w times each vector component
  always_comb begin
    logic signed [31:0] ws;
    ws         = $signed({1'b0, sqa_r[SQ].sq.root});
    m_nxt.wx   = ws * sqa_r[SQ].side.x;
    m_nxt.wy   = ws * sqa_r[SQ].side.y;
    m_nxt.wz   = ws * sqa_r[SQ].side.z;
    m_nxt.xy   = sqa_r[SQ].side.xy;
    m_nxt.yz   = sqa_r[SQ].side.yz;
    m_nxt.zx   = sqa_r[SQ].side.zx;
    m_nxt.t1   = sqa_r[SQ].side.t1;
    m_nxt.t4   = sqa_r[SQ].side.t4;
    m_nxt.flag = sqa_r[SQ].side.flag;
  end

  // sine-side terms of the three angles
  always_comb begin
    t_nxt.t0   = 65'(m_r.wx) + 65'(m_r.yz);
    t_nxt.t2   = 65'(m_r.wy) - 65'(m_r.zx);
    t_nxt.t3   = 65'(m_r.wz) + 65'(m_r.xy);
    t_nxt.t1   = m_r.t1;
    t_nxt.t4   = m_r.t4;
    t_nxt.flag = m_r.flag;
  end

  // asin argument clamped to one and cut to q30
  always_comb begin
    logic [63:0] mg;
    logic [63:0] cl;
    mg           = q2e_pkg::mag65(t_r.t2);
    cl           = (mg > q2e_pkg::ONE59) ? q2e_pkg::ONE59 : mg;
    p1_nxt.u     = cl[59:29];
    p1_nxt.t2neg = t_r.t2[64];
    p1_nxt.t0    = t_r.t0;
    p1_nxt.t1    = t_r.t1;
    p1_nxt.t3    = t_r.t3;
    p1_nxt.t4    = t_r.t4;
    p1_nxt.flag  = t_r.flag;
  end

  always_comb begin
    p2_nxt.uu   = 62'(p1_r.u * p1_r.u);
    p2_nxt.side = p1_r;
  end

  always_comb begin
    logic [61:0] rad;
    rad          = 62'(q2e_pkg::ONE60) - p2_r.uu;
    sb0_nxt.sq   = '0;
    sb0_nxt.src  = rad;
    sb0_nxt.side = p2_r.side;
  end

  // asin cosine: one root bit per stage
  for (genvar k = 1; k <= SQ; k++) begin : g_sqrt_c
    always_ff @(posedge clk) begin
      if (adv) begin
        sqb_r[k].sq   <= q2e_pkg::sqrt_step(sqb_r[k-1].sq, sqb_r[k-1].src[61:60]);
        sqb_r[k].src  <= {sqb_r[k-1].src[59:0], 2'b00};
        sqb_r[k].side <= sqb_r[k-1].side;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r     <= s1_nxt;
      sqa_r[0] <= sa0_nxt;
      m_r      <= m_nxt;
      t_r      <= t_nxt;
      p1_r     <= p1_nxt;
      p2_r     <= p2_nxt;
      sqb_r[0] <= sb0_nxt;
    end
  end

  // arctangent operands, all three units run in lockstep
  always_comb begin
    roll_op.ax       = q2e_pkg::mag65(sqb_r[SQ].side.t1);
    roll_op.ay       = q2e_pkg::mag65(sqb_r[SQ].side.t0);
    roll_op.den_neg  = sqb_r[SQ].side.t1[64];
    roll_op.num_neg  = sqb_r[SQ].side.t0[64];
    yaw_op.ax        = q2e_pkg::mag65(sqb_r[SQ].side.t4);
    yaw_op.ay        = q2e_pkg::mag65(sqb_r[SQ].side.t3);
    yaw_op.den_neg   = sqb_r[SQ].side.t4[64];
    yaw_op.num_neg   = sqb_r[SQ].side.t3[64];
    pitch_op.ax      = {33'd0, sqb_r[SQ].sq.root};
    pitch_op.ay      = {33'd0, sqb_r[SQ].side.u};
    pitch_op.den_neg = 1'b0;
    pitch_op.num_neg = sqb_r[SQ].side.t2neg;
  end

  q2e_atan u_roll (
    .clk (clk),
    .en  (adv),
    .op  (roll_op),
    .ang (roll_ang)
  );

  q2e_atan u_pitch (
    .clk (clk),
    .en  (adv),
    .op  (pitch_op),
    .ang (pitch_ang)
  );

  q2e_atan u_yaw (
    .clk (clk),
    .en  (adv),
    .op  (yaw_op),
    .ang (yaw_ang)
  );

  // norm flag waits out the arctangent latency
  always_ff @(posedge clk) begin
    if (adv) begin
      flag_dly_r <= {flag_dly_r[q2e_pkg::ATAN_LAT-2:0], sqb_r[SQ].side.flag};
    end
  end

  // valid bits and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      vld_r        <= {vld_r[LAT-2:0], in_tvalid};
      out_tvalid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= {6'd0, yaw_ang, pitch_ang[15:0], roll_ang};
      out_tuser_r <= flag_dly_r[q2e_pkg::ATAN_LAT-1];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // a clamped norm must leave a zero scalar part
  `Q2E_ASSERT_IMPL(a_clamp_zero_root, vld_r[A_END] && sqa_r[SQ].side.flag, sqa_r[SQ].sq.root == '0)
  // the asin argument never exceeds one
  `Q2E_ASSERT_IMPL(a_pitch_arg_range, vld_r[P1_IDX], p1_r.u <= U_MAX)
  // a stall freezes every valid bit
  `Q2E_ASSERT_NEXT(a_hold_on_stall, !adv, $stable(vld_r))

endmodule

// ===== rtl/q2e_atan.sv =====
// pipelined four-quadrant arctangent: normalize, cordic vectoring, round to angle field
module q2e_atan (
  input  logic                             clk,
  input  logic                             en,
  input  q2e_pkg::atan_in_t                op,
  output logic [q2e_pkg::ANGLE_W-1:0]      ang
);

  typedef enum logic [1:0] {
    SP_NONE,
    SP_ZERO,
    SP_NINETY
  } spec_t;

  typedef struct packed {
    logic signed [q2e_pkg::XW-1:0] x;
    logic signed [q2e_pkg::XW-1:0] y;
    logic signed [q2e_pkg::ZW-1:0] z;
    spec_t                         spec;
    logic                          den_neg;
    logic                          num_neg;
  } cd_t;

  q2e_pkg::atan_in_t norm_r [q2e_pkg::NORM_STEPS];
  cd_t               cd_r   [q2e_pkg::CORDIC_STEPS];
  cd_t               cd_in;

  logic signed [q2e_pkg::ZW-1:0] a_r;
  logic signed [q2e_pkg::ZW-1:0] a_nxt;
  logic [q2e_pkg::ANGLE_W-1:0]   ang_r;
  logic [q2e_pkg::ANGLE_W-1:0]   ang_nxt;

  // left-align the larger magnitude, one shift size per stage
  for (genvar j = 0; j < q2e_pkg::NORM_STEPS; j++) begin : g_norm
    localparam int S = 32 >> j;
    q2e_pkg::atan_in_t prv;
    q2e_pkg::atan_in_t nrm_nxt;
    logic [63:0]       orv;
    if (j == 0) begin : g_first
      assign prv = op;
    end else begin : g_rest
      assign prv = norm_r[j-1];
    end
    assign orv = prv.ax | prv.ay;
    always_comb begin
      nrm_nxt = prv;
      if (orv[63 -: S] == '0) begin
        nrm_nxt.ax = prv.ax << S;
        nrm_nxt.ay = prv.ay << S;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        norm_r[j] <= nrm_nxt;
      end
    end
  end

  // top 30 bits put the larger operand in [2^29, 2^30)
  always_comb begin
    cd_in.x       = $signed({4'b0000, norm_r[q2e_pkg::NORM_STEPS-1].ax[63:34]});
    cd_in.y       = $signed({4'b0000, norm_r[q2e_pkg::NORM_STEPS-1].ay[63:34]});
    cd_in.z       = '0;
    cd_in.den_neg = norm_r[q2e_pkg::NORM_STEPS-1].den_neg;
    cd_in.num_neg = norm_r[q2e_pkg::NORM_STEPS-1].num_neg;
    if (norm_r[q2e_pkg::NORM_STEPS-1].ay[63:34] == '0) begin
      cd_in.spec = SP_ZERO;
    end else if (norm_r[q2e_pkg::NORM_STEPS-1].ax[63:34] == '0) begin
      cd_in.spec = SP_NINETY;
    end else begin
      cd_in.spec = SP_NONE;
    end
  end

  for (genvar i = 0; i < q2e_pkg::CORDIC_STEPS; i++) begin : g_cordic
    cd_t                           prv;
    cd_t                           cd_nxt;
    logic signed [q2e_pkg::XW-1:0] xs;
    logic signed [q2e_pkg::XW-1:0] ys;
    logic signed [q2e_pkg::ZW-1:0] tab;
    if (i == 0) begin : g_first
      assign prv = cd_in;
    end else begin : g_rest
      assign prv = cd_r[i-1];
    end
    assign xs  = prv.x >>> i;
    assign ys  = prv.y >>> i;
    assign tab = $signed({2'b00, q2e_pkg::atan_entry(5'(i))});
    always_comb begin
      cd_nxt = prv;
      if (!prv.y[q2e_pkg::XW-1]) begin
        cd_nxt.x = prv.x + ys;
        cd_nxt.y = prv.y - xs;
        cd_nxt.z = prv.z + tab;
      end else begin
        cd_nxt.x = prv.x - ys;
        cd_nxt.y = prv.y + xs;
        cd_nxt.z = prv.z - tab;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cd_r[i] <= cd_nxt;
      end
    end
  end

  // clamp to the first quadrant, then place in the right quadrant
  always_comb begin
    cd_t                           lst;
    logic signed [q2e_pkg::ZW-1:0] a;
    lst = cd_r[q2e_pkg::CORDIC_STEPS-1];
    case (lst.spec)
      SP_ZERO:   a = '0;
      SP_NINETY: a = q2e_pkg::DEG90;
      SP_NONE: begin
        if (lst.z < 0) begin
          a = '0;
        end else if (lst.z > q2e_pkg::DEG90) begin
          a = q2e_pkg::DEG90;
        end else begin
          a = lst.z;
        end
      end
      default:   a = '0;
    endcase
    if (lst.den_neg) begin
      a = q2e_pkg::DEG180 - a;
    end
    if (lst.num_neg) begin
      a = -a;
    end
    a_nxt = a;
  end

  // round half up on the magnitude, restore the sign, keep the field bits
  always_comb begin
    logic [q2e_pkg::ZW-1:0] mag;
    logic [q2e_pkg::ZW-1:0] rnd;
    logic [q2e_pkg::ZW-1:0] fld;
    mag     = a_r[q2e_pkg::ZW-1] ? q2e_pkg::ZW'(-a_r) : q2e_pkg::ZW'(a_r);
    rnd     = (mag + (q2e_pkg::ZW'(1) << (q2e_pkg::RND_SHIFT - 1))) >> q2e_pkg::RND_SHIFT;
    fld     = a_r[q2e_pkg::ZW-1] ? q2e_pkg::ZW'(-rnd) : rnd;
    ang_nxt = fld[q2e_pkg::ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= a_nxt;
      ang_r <= ang_nxt;
    end
  end

  assign ang = ang_r;

endmodule

// ===== test/q2e_checker.sv =====
// checker for the quaternion to euler angles block: predicts angles and compares results
`timescale 1ns / 100ps

module q2e_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending_count,
  output int          result_count,
  output int          clamp_count
);

  localparam longint Q16_90  = 64'sd90 << 16;
  localparam longint Q16_180 = 64'sd180 << 16;

  typedef struct {
    logic [16:0] roll;
    logic [15:0] pitch;
    logic [16:0] yaw;
    logic        clamped;
  } euler_t;

  euler_t angle_queue[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] abs64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint one_less(input logic [63:0] sq);
    if (sq <= q2e_pkg::ONE59) return longint'(q2e_pkg::ONE59 - sq);
    return -longint'(sq - q2e_pkg::ONE59);
  endfunction

  // first-quadrant arctangent by vectoring cordic, q16 degrees
  function automatic longint quad_atan(input logic [63:0] ax, input logic [63:0] ay);
    logic [63:0] m;
    longint x, y, z, nx;
    z = 0;
    if (ay == 0) return 0;
    if (ax == 0) return Q16_90;
    m = ax > ay ? ax : ay;
    while (m >= (64'd1 << 30)) begin
      ax = ax >> 1; ay = ay >> 1; m = m >> 1;
    end
    while (m < (64'd1 << 29)) begin
      ax = ax << 1; ay = ay << 1; m = m << 1;
    end
    if (ay == 0) return 0;
    if (ax == 0) return Q16_90;
    x = longint'(ax);
    y = longint'(ay);
    for (int i = 0; i < q2e_pkg::CORDIC_STEPS; i++) begin
      // arithmetic shift is a floor shift
      if (y >= 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(q2e_pkg::atan_entry(5'(i)));
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(q2e_pkg::atan_entry(5'(i)));
      end
      x = nx;
    end
    if (z < 0) z = 0;
    if (z > Q16_90) z = Q16_90;
    return z;
  endfunction

  function automatic longint full_atan2(input longint num, input longint den);
    longint a;
    a = quad_atan(abs64(den), abs64(num));
    if (den < 0) a = Q16_180 - a;
    if (num < 0) a = -a;
    return a;
  endfunction

  function automatic logic [16:0] round_angle(input longint a);
    logic [63:0] r;
    r = (abs64(a) + (64'd1 << (q2e_pkg::RND_SHIFT - 1))) >> q2e_pkg::RND_SHIFT;
    if (a < 0) r = -r;
    return r[16:0];
  endfunction

  function automatic euler_t predict_euler(input logic [95:0] d);
    longint x, y, z, w, t0, t2, t3, pitch;
    logic [63:0] xx, yy, zz, sum, u, c;
    euler_t e;
    x = longint'($signed(d[31:0]));
    y = longint'($signed(d[63:32]));
    z = longint'($signed(d[95:64]));
    xx = x * x; yy = y * y; zz = z * z;
    sum = xx + yy + zz;
    w = 0;
    e.clamped = sum > q2e_pkg::ONE60;
    if (!e.clamped) w = longint'(int_sqrt(q2e_pkg::ONE60 - sum));
    t0 = w * x + y * z;
    t2 = w * y - z * x;
    t3 = w * z + x * y;
    u = abs64(t2);
    if (u > q2e_pkg::ONE59) u = q2e_pkg::ONE59;
    u = u >> 29;
    c = int_sqrt(q2e_pkg::ONE60 - u * u);
    pitch = quad_atan(c, u);
    if (t2 < 0) pitch = -pitch;
    e.roll  = round_angle(full_atan2(t0, one_less(xx + yy)));
    e.pitch = 16'(round_angle(pitch));
    e.yaw   = round_angle(full_atan2(t3, one_less(yy + zz)));
    return e;
  endfunction

  always @(posedge clk) begin
    euler_t exp_e;
    if (!rst_n) begin
      fail_count    <= 0;
      result_count  <= 0;
      clamp_count   <= 0;
      pending_count <= 0;
    end else begin
      if (in_tvalid && in_tready) angle_queue.push_back(predict_euler(in_tdata));
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        if (angle_queue.size() == 0) begin
          $display("%0t: result with nothing expected: data %h flag %b",
                   $time, out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_e = angle_queue.pop_front();
          if (exp_e.clamped) clamp_count <= clamp_count + 1;
          if (out_tdata[16:0] !== exp_e.roll || out_tdata[32:17] !== exp_e.pitch ||
              out_tdata[49:33] !== exp_e.yaw || out_tdata[55:50] !== 6'd0 ||
              out_tuser !== exp_e.clamped) begin
            $display("%0t: expected roll %h pitch %h yaw %h flag %b, got %h %h %h %b (%h)",
                     $time, exp_e.roll, exp_e.pitch, exp_e.yaw, exp_e.clamped,
                     out_tdata[16:0], out_tdata[32:17], out_tdata[49:33], out_tuser,
                     out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= angle_queue.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// testbench top: drives quaternion stimulus with random stalls and reports the verdict
`timescale 1ns / 100ps

module tb_top;

  localparam int     RANDOM_ITEMS = 550;
  localparam int     HOLD_CYCLES  = 300;   // long receiver hold-off to fill the pipe
  localparam int     DRAIN_CYCLES = 200;   // well over the pipeline latency
  localparam longint CYCLE_LIMIT  = 200000;
  localparam int     ONE_Q30      = 32'sh4000_0000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;    // quat_x [31:0], quat_y [63:32], quat_z [95:64]
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;   // roll [16:0], pitch [32:17], yaw [49:33]
  logic        out_tuser;   // norm_clamped [0]

  int     fail_count, pending_count, result_count, clamp_count;
  int     sent_count;
  longint cycle_count = 0;
  logic   hold_active;
  logic   calm_phase;       // stretch where neither side idles

  quaternion_to_euler_angles_top u_dut (.*);

  q2e_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .fail_count, .pending_count, .result_count, .clamp_count
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, pending_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off, none during the calm stretch
  initial begin
    int   hold_left;
    logic hold_used;
    out_tready = 1'b0;
    hold_left  = 0;
    hold_used  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_active && !hold_used) begin
        hold_left = HOLD_CYCLES;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_tready <= 1'b0;
      end else if (calm_phase) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 30);
      end
    end
  end

  // random q30 component, mostly in range, sometimes at or past the edges
  function automatic logic [31:0] rand_comp();
    int k;
    k = $urandom_range(9);
    if (k == 0) return $urandom();
    if (k == 1) return $urandom_range(3) == 0 ? -ONE_Q30 : ONE_Q30;
    if (k == 2) return 32'($signed($urandom_range(2000)) - 1000);
    return 32'($signed($urandom_range(32'h7FFF_FFFF)) - ONE_Q30);
  endfunction

  // random unit-ish quaternion: scale components so the norm stays below one
  function automatic logic [95:0] rand_unit();
    logic [31:0] x, y, z;
    int sh;
    sh = $urandom_range(3);
    x = $signed($urandom_range(32'h7FFF_FFFF) - ONE_Q30) >>> (sh + 1);
    y = $signed($urandom_range(32'h7FFF_FFFF) - ONE_Q30) >>> (sh + 1);
    z = $signed($urandom_range(32'h7FFF_FFFF) - ONE_Q30) >>> (sh + 1);
    return {z, y, x};
  endfunction

  task automatic send_quat(input logic [95:0] d);
    while (!calm_phase && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] h;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    hold_active = 1'b0;
    calm_phase  = 1'b0;
    sent_count  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    h = 32'h2D41_3CCD;  // about 1/sqrt(2) in q30

    // directed: identity, axis extremes, gimbal lock, norm exactly one and above
    send_quat({32'd0, 32'd0, 32'd0});
    send_quat({32'd0, 32'd0, 32'(ONE_Q30)});
    send_quat({32'd0, 32'd0, 32'(-ONE_Q30)});
    send_quat({32'd0, 32'(ONE_Q30), 32'd0});
    send_quat({32'd0, 32'(-ONE_Q30), 32'd0});
    send_quat({32'(ONE_Q30), 32'd0, 32'd0});
    send_quat({32'(-ONE_Q30), 32'd0, 32'd0});
    send_quat({32'd0, h, 32'd0});
    send_quat({32'd0, -h, 32'd0});
    send_quat({32'd0, h, h});
    send_quat({h, 32'd0, h});
    send_quat({h, h, 32'd0});
    send_quat({32'(ONE_Q30), 32'(ONE_Q30), 32'(ONE_Q30)});
    send_quat({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_quat({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_quat({32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF});
    send_quat({32'd1, 32'd0, 32'd0});
    send_quat({32'd0, 32'd0, 32'hFFFF_FFFF});
    send_quat({32'h2000_0000, 32'h2000_0000, 32'h2000_0000});
    send_quat({32'hE000_0000, 32'h2000_0000, 32'hE000_0000});
    send_quat({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});

    // random part with a long output hold-off near the start
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 20) hold_active = 1'b1;
      calm_phase = (i >= 300 && i < 380);
      if ($urandom_range(3) == 0) send_quat({rand_comp(), rand_comp(), rand_comp()});
      else send_quat(rand_unit());
    end
    calm_phase = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d quaternions, checked %0d results, %0d with the norm clamped",
             sent_count, result_count, clamp_count);
    $display("covered axis extremes, gimbal lock, out-of-range norms and random attitudes");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
